[rtl/gstwb_pkg.sv]
// Shared types and constants for the grid spanning-tree wall breaker.
package gstwb_pkg;

	localparam int unsigned GRID_WIDTH  = 16;
	localparam int unsigned GRID_HEIGHT = 16;
	localparam int unsigned CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
	localparam int unsigned WALL_TARGET = CELL_COUNT - 1;
	localparam int unsigned CELL_W      = $clog2(CELL_COUNT);

	localparam logic MODE_PROPOSE = 1'b0;
	localparam logic MODE_READ    = 1'b1;
	localparam logic SIDE_NORTH   = 1'b0;
	localparam logic SIDE_WEST    = 1'b1;

	typedef logic [CELL_W-1:0] cell_idx_t;

	typedef struct packed {
		logic       mode;
		logic [3:0] cell_x;
		logic [3:0] cell_y;
		logic       wall_side;
	} cmd_item_t;

	typedef struct packed {
		logic       wall_removed;
		logic       maze_done;
		logic [7:0] removed_count;
		logic       north_present;
		logic       west_present;
	} rsp_item_t;

	// One RAM word per cell: both wall bits and the set label.
	typedef struct packed {
		logic      north;
		logic      west;
		cell_idx_t label;
	} cell_word_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD_C,
		ST_RD_N,
		ST_CMP,
		ST_SCAN,
		ST_SCAN_END,
		ST_OUT
	} state_t;

endpackage

[rtl/gstwb_if.sv]
// Valid/ready channel interfaces for the command and response beats.
interface gstwb_cmd_if;
	logic                 valid;
	logic                 ready;
	gstwb_pkg::cmd_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface gstwb_rsp_if;
	logic                 valid;
	logic                 ready;
	gstwb_pkg::rsp_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

[rtl/gstwb_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
module gstwb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/grid_spanning_tree_wall_breaker_top.sv]
// Kruskal-style maze builder: set labels and wall bits in one RAM, one scan unit.
// Each command passes ST_RD_C, ST_RD_N, ST_CMP and ST_OUT before the result register loads;
// a removal adds a relabel scan (ST_SCAN over every cell, then ST_SCAN_END) before ST_OUT.
// One item at a time: ST_OUT waits for the response slot, then the next beat is taken in ST_IDLE.
// Reset: a clearing pass writes every cell's label and walls;
// cmd.ready stays low until it ends.
module grid_spanning_tree_wall_breaker_top (
	input  logic              clk,
	input  logic              arst_n,
	gstwb_cmd_if.sink         cmd,
	gstwb_rsp_if.source       rsp
);

	gstwb_pkg::state_t     state_q, state_d;
	gstwb_pkg::cell_idx_t  cnt_q;
	gstwb_pkg::cell_idx_t  c_q, n_q;
	gstwb_pkg::cell_idx_t  theirs_q;
	gstwb_pkg::cell_idx_t  addr_s1;
	logic                  pend_s1;
	logic                  mode_q, side_q, inside_q, removed_q;
	gstwb_pkg::cell_word_t word_c_q;
	gstwb_pkg::cell_idx_t  walls_down_q;
	logic                  out_valid_q;
	gstwb_pkg::rsp_item_t  out_q;

	logic                  ram_we;
	gstwb_pkg::cell_idx_t  ram_waddr, ram_raddr;
	gstwb_pkg::cell_word_t ram_wdata, ram_rdata;

	logic                  cnt_last, do_remove, scan_hit, out_free;
	logic                  wall_up, border_q;
	gstwb_pkg::cell_idx_t  cmd_c;
	logic                  cmd_inside;
	gstwb_pkg::cell_word_t word_c_cleared;

	gstwb_ram #(
		.WIDTH ($bits(gstwb_pkg::cell_word_t)),
		.DEPTH (gstwb_pkg::CELL_COUNT)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cnt_last   = (cnt_q == gstwb_pkg::cell_idx_t'(gstwb_pkg::CELL_COUNT - 1));
	assign cmd_inside = (32'(cmd.item.cell_x) < gstwb_pkg::GRID_WIDTH) &&
	                    (32'(cmd.item.cell_y) < gstwb_pkg::GRID_HEIGHT);
	assign cmd_c      = gstwb_pkg::cell_idx_t'(
	                    gstwb_pkg::cell_idx_t'(cmd.item.cell_y) *
	                    gstwb_pkg::cell_idx_t'(gstwb_pkg::GRID_WIDTH) +
	                    gstwb_pkg::cell_idx_t'(cmd.item.cell_x));

	// word_c_q holds cell c; ram_rdata holds the neighbor while in ST_CMP
	assign wall_up   = (side_q == gstwb_pkg::SIDE_NORTH) ? word_c_q.north : word_c_q.west;
	assign do_remove = (mode_q == gstwb_pkg::MODE_PROPOSE) && inside_q && wall_up && !border_q &&
	                   (32'(walls_down_q) < gstwb_pkg::WALL_TARGET) &&
	                   (ram_rdata.label != word_c_q.label);
	assign scan_hit  = pend_s1 && (ram_rdata.label == theirs_q);
	assign out_free  = !out_valid_q || rsp.ready;

	always_comb begin
		word_c_cleared = word_c_q;
		if (side_q == gstwb_pkg::SIDE_NORTH) begin
			word_c_cleared.north = 1'b0;
		end else begin
			word_c_cleared.west = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_q <= 1'b0;
		end else if (state_q == gstwb_pkg::ST_IDLE && cmd.valid) begin
			border_q <= (cmd.item.wall_side == gstwb_pkg::SIDE_NORTH) ?
			            (cmd.item.cell_y == 4'd0) : (cmd.item.cell_x == 4'd0);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gstwb_pkg::ST_INIT:     if (cnt_last) state_d = gstwb_pkg::ST_IDLE;
			gstwb_pkg::ST_IDLE:     if (cmd.valid) state_d = gstwb_pkg::ST_RD_C;
			gstwb_pkg::ST_RD_C:     state_d = gstwb_pkg::ST_RD_N;
			gstwb_pkg::ST_RD_N:     state_d = gstwb_pkg::ST_CMP;
			gstwb_pkg::ST_CMP:      state_d = do_remove ? gstwb_pkg::ST_SCAN : gstwb_pkg::ST_OUT;
			gstwb_pkg::ST_SCAN:     if (cnt_last) state_d = gstwb_pkg::ST_SCAN_END;
			gstwb_pkg::ST_SCAN_END: state_d = gstwb_pkg::ST_OUT;
			gstwb_pkg::ST_OUT:      if (out_free) state_d = gstwb_pkg::ST_IDLE;
			default:                state_d = gstwb_pkg::ST_INIT;
		endcase
	end

	// RAM control and handshake
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = '{north: ram_rdata.north, west: ram_rdata.west, label: word_c_q.label};
		ram_raddr = cnt_q;
		cmd.ready = 1'b0;
		case (state_q)
			gstwb_pkg::ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = '{north: 1'b1, west: 1'b1, label: cnt_q};
			end
			gstwb_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
			end
			gstwb_pkg::ST_RD_C: begin
				ram_raddr = c_q;
			end
			gstwb_pkg::ST_RD_N: begin
				ram_raddr = n_q;
			end
			gstwb_pkg::ST_CMP: begin
				ram_we    = do_remove;
				ram_waddr = c_q;
				ram_wdata = word_c_cleared;
			end
			gstwb_pkg::ST_SCAN, gstwb_pkg::ST_SCAN_END: begin
				ram_we = scan_hit;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= gstwb_pkg::ST_INIT;
			cnt_q        <= '0;
			pend_s1      <= 1'b0;
			walls_down_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == gstwb_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				gstwb_pkg::ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
				end
				gstwb_pkg::ST_CMP: begin
					cnt_q <= '0;
					if (do_remove) begin
						walls_down_q <= walls_down_q + 1'b1;
					end
				end
				gstwb_pkg::ST_SCAN: begin
					cnt_q   <= cnt_q + 1'b1;
					pend_s1 <= 1'b1;
				end
				gstwb_pkg::ST_SCAN_END: begin
					pend_s1 <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q;
		case (state_q)
			gstwb_pkg::ST_IDLE: begin
				mode_q   <= cmd.item.mode;
				side_q   <= cmd.item.wall_side;
				inside_q <= cmd_inside;
				c_q      <= cmd_c;
				n_q      <= (cmd.item.wall_side == gstwb_pkg::SIDE_NORTH) ?
				            gstwb_pkg::cell_idx_t'(cmd_c -
				                gstwb_pkg::cell_idx_t'(gstwb_pkg::GRID_WIDTH)) :
				            gstwb_pkg::cell_idx_t'(cmd_c - 1'b1);
			end
			gstwb_pkg::ST_RD_N: begin
				word_c_q <= ram_rdata;
			end
			gstwb_pkg::ST_CMP: begin
				removed_q <= do_remove;
				theirs_q  <= ram_rdata.label;
				if (do_remove) begin
					word_c_q <= word_c_cleared;
				end
			end
			gstwb_pkg::ST_OUT: begin
				if (out_free) begin
					out_q.wall_removed  <= removed_q;
					out_q.maze_done     <= (32'(walls_down_q) == gstwb_pkg::WALL_TARGET);
					out_q.removed_count <= (32'(walls_down_q) > 32'd255) ?
					                       8'd255 : 8'(walls_down_q);
					out_q.north_present <= inside_q & word_c_q.north;
					out_q.west_present  <= inside_q & word_c_q.west;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.item  = out_q;

endmodule
